// ===== src/hsg_pkg.sv =====
// ----------------------------------------------------------------------------
// hsg_pkg: shared constants and the prime base table
// Widths and defaults shared by the Halton generator core and its parts.
// ----------------------------------------------------------------------------
package hsg_pkg;

  localparam int MAX_DIM_DEF   = 8;
  localparam int FRAC_BITS_DEF = 32;
  localparam int DIGIT_W       = 8;   // largest base 131 fits in 8 bits
  localparam int PRIME_CNT     = 32;
  localparam int MAX_DIGITS    = 32;  // base 2 digits of a 32-bit index

  // Configuration register indexes
  localparam logic CFG_DIM_COUNT   = 1'b0;
  localparam logic CFG_START_INDEX = 1'b1;

  function automatic logic [DIGIT_W-1:0] prime_of(input logic [4:0] idx);
    logic [DIGIT_W-1:0] p;
    case (idx)
      5'd0:  p = 8'd2;
      5'd1:  p = 8'd3;
      5'd2:  p = 8'd5;
      5'd3:  p = 8'd7;
      5'd4:  p = 8'd11;
      5'd5:  p = 8'd13;
      5'd6:  p = 8'd17;
      5'd7:  p = 8'd19;
      5'd8:  p = 8'd23;
      5'd9:  p = 8'd29;
      5'd10: p = 8'd31;
      5'd11: p = 8'd37;
      5'd12: p = 8'd41;
      5'd13: p = 8'd43;
      5'd14: p = 8'd47;
      5'd15: p = 8'd53;
      5'd16: p = 8'd59;
      5'd17: p = 8'd61;
      5'd18: p = 8'd67;
      5'd19: p = 8'd71;
      5'd20: p = 8'd73;
      5'd21: p = 8'd79;
      5'd22: p = 8'd83;
      5'd23: p = 8'd89;
      5'd24: p = 8'd97;
      5'd25: p = 8'd101;
      5'd26: p = 8'd103;
      5'd27: p = 8'd107;
      5'd28: p = 8'd109;
      5'd29: p = 8'd113;
      5'd30: p = 8'd127;
      default: p = 8'd131;
    endcase
    return p;
  endfunction

endpackage

// ===== src/hsg_ram.sv =====
// ----------------------------------------------------------------------------
// hsg_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module hsg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/hsg_div.sv =====
// ----------------------------------------------------------------------------
// hsg_div: restoring divider by a small base
// One quotient bit per cycle; done pulses with quotient and remainder valid.
// ----------------------------------------------------------------------------
module hsg_div #(
  parameter int NW = 40
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [NW-1:0]              num,
  input  logic [hsg_pkg::DIGIT_W-1:0] base,
  output logic                       done,
  output logic [NW-1:0]              quot,
  output logic [hsg_pkg::DIGIT_W-1:0] rem
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0]               q_r;
  logic [hsg_pkg::DIGIT_W-1:0] r_r;
  logic [CW-1:0]               cnt_r;
  logic                        busy_r;
  logic                        done_r;
  logic [hsg_pkg::DIGIT_W:0]   part;
  logic [hsg_pkg::DIGIT_W:0]   diff;
  logic                        ge;

  always_comb begin
    part = {r_r, q_r[NW-1]};
    diff = part - {1'b0, base};
    ge   = (part >= {1'b0, base});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift in one numerator bit, subtract base where it fits
  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= num;
      r_r <= '0;
    end else if (busy_r) begin
      q_r <= {q_r[NW-2:0], ge};
      r_r <= ge ? diff[hsg_pkg::DIGIT_W-1:0] : part[hsg_pkg::DIGIT_W-1:0];
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r;

endmodule

// ===== src/halton_sequence_generator_core.sv =====
// ----------------------------------------------------------------------------
// halton_sequence_generator_core: Halton point generator
// Each request with request=1 yields one point: one coordinate per active
// dimension, dimension d in base prime(d+1), the last one flagged.
// ----------------------------------------------------------------------------
// Usage: write dim_count (index 0) and start_index (index 1) while idle; a
// start_index write also loads the index counter. Each accepted item with
// request=1 emits dim_count coordinates (clamped to 1..MAX_DIM) as unsigned
// 32-bit fractions, truncated; request=0 is taken and dropped. One item is in
// work at a time. Digit extraction and the nested long division both run
// through one bit-serial divider, NW = max(32, FRAC_BITS+8), that resolves
// one quotient bit per cycle; digits are parked in a 32-entry digit RAM
// between the two passes. An index of zero skips both passes and gives a
// zero coordinate. The output waits in place until taken.
// ----------------------------------------------------------------------------
module halton_sequence_generator_core #(
  parameter int MAX_DIM   = hsg_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = hsg_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_request,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_coordinate,
  output logic [2:0]  out_dim_index,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int NW  = (FRAC_BITS + hsg_pkg::DIGIT_W > 32) ?
                       FRAC_BITS + hsg_pkg::DIGIT_W : 32;
  localparam int DW  = $clog2(MAX_DIM + 1);
  localparam int AW  = $clog2(hsg_pkg::MAX_DIGITS);
  localparam int NDW = AW + 1;
  localparam int SHR = (FRAC_BITS >= 32) ? FRAC_BITS - 32 : 0;
  localparam int SHL = (FRAC_BITS >= 32) ? 0 : 32 - FRAC_BITS;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_EXT_GO   = 7'b0000010,
    ST_EXT_WAIT = 7'b0000100,
    ST_ACC_RD   = 7'b0001000,
    ST_ACC_GO   = 7'b0010000,
    ST_ACC_WAIT = 7'b0100000,
    ST_OUT      = 7'b1000000
  } state_t;

  state_t                      state_r;
  logic [3:0]                  dim_count_r;
  logic [31:0]                 index_cnt_r;
  logic [DW-1:0]               d_r;
  logic [DW-1:0]               n_r;
  logic [31:0]                 v_r;
  logic [FRAC_BITS-1:0]        y_r;
  logic [NDW-1:0]              ndig_r;

  logic [DW-1:0]               n_eff;
  logic [hsg_pkg::DIGIT_W-1:0] base;
  logic                        div_start;
  logic [NW-1:0]               div_num;
  logic                        div_done;
  logic [NW-1:0]               div_quot;
  logic [hsg_pkg::DIGIT_W-1:0] div_rem;
  logic                        ram_we;
  logic [AW-1:0]               ram_raddr;
  logic [hsg_pkg::DIGIT_W-1:0] ram_rdata;
  logic [31:0]                 coord;
  logic                        last;

  // clamp the dimension count to 1..MAX_DIM
  always_comb begin
    if (dim_count_r == 4'd0) begin
      n_eff = DW'(1);
    end else if (32'(dim_count_r) > 32'(MAX_DIM)) begin
      n_eff = DW'(MAX_DIM);
    end else begin
      n_eff = DW'(dim_count_r);
    end
  end

  assign base = hsg_pkg::prime_of(5'(d_r));
  assign last = (d_r + 1'b1 == n_r);

  always_comb begin
    div_start = 1'b0;
    div_num   = NW'(v_r);
    if (state_r == ST_EXT_GO) begin
      div_start = 1'b1;
    end else if (state_r == ST_ACC_GO) begin
      div_start = 1'b1;
      div_num   = (NW'(ram_rdata) << FRAC_BITS) | NW'(y_r);
    end
  end

  assign ram_we    = (state_r == ST_EXT_WAIT) && div_done;
  assign ram_raddr = AW'(ndig_r - 1'b1);

  // bring the fraction to 32 bits
  always_comb begin
    if (FRAC_BITS >= 32) begin
      coord = 32'(y_r >> SHR);
    end else begin
      coord = 32'(y_r) << SHL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dim_count_r <= 4'd1;
      index_cnt_r <= '0;
      d_r         <= '0;
      n_r         <= DW'(1);
      ndig_r      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          hsg_pkg::CFG_DIM_COUNT:   dim_count_r <= cfg_wdata[3:0];
          hsg_pkg::CFG_START_INDEX: index_cnt_r <= cfg_wdata;
          default: ;
        endcase
      end
      case (state_r)
        ST_IDLE: begin
          // take one item; drop it when it does not request a point
          if (in_valid && in_request) begin
            n_r    <= n_eff;
            d_r    <= '0;
            ndig_r <= '0;
            state_r <= (index_cnt_r == 32'd0) ? ST_OUT : ST_EXT_GO;
          end
        end
        ST_EXT_GO: state_r <= ST_EXT_WAIT;
        ST_EXT_WAIT: begin
          if (div_done) begin
            ndig_r <= ndig_r + 1'b1;
            if (div_quot[31:0] == 32'd0 ||
                ndig_r == NDW'(hsg_pkg::MAX_DIGITS - 1)) begin
              state_r <= ST_ACC_RD;
            end else begin
              state_r <= ST_EXT_GO;
            end
          end
        end
        ST_ACC_RD: begin
          ndig_r  <= ndig_r - 1'b1;
          state_r <= ST_ACC_GO;
        end
        ST_ACC_GO: state_r <= ST_ACC_WAIT;
        ST_ACC_WAIT: begin
          if (div_done) begin
            state_r <= (ndig_r == '0) ? ST_OUT : ST_ACC_RD;
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            if (last) begin
              index_cnt_r <= index_cnt_r + 1'b1;
              state_r     <= ST_IDLE;
            end else begin
              // advance to the next dimension, same index
              d_r     <= d_r + 1'b1;
              ndig_r  <= '0;
              state_r <= (index_cnt_r == 32'd0) ? ST_OUT : ST_EXT_GO;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // datapath registers: remaining index and partial fraction
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        v_r <= index_cnt_r;
        y_r <= '0;
      end
      ST_EXT_WAIT: begin
        if (div_done) begin
          v_r <= div_quot[31:0];
        end
      end
      ST_ACC_WAIT: begin
        if (div_done) begin
          y_r <= div_quot[FRAC_BITS-1:0];
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          v_r <= index_cnt_r;
          y_r <= '0;
        end
      end
      default: ;
    endcase
  end

  hsg_div #(
    .NW(NW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .base  (base),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  hsg_ram #(
    .WIDTH(hsg_pkg::DIGIT_W),
    .DEPTH(hsg_pkg::MAX_DIGITS)
  ) u_digits (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ndig_r[AW-1:0]),
    .wdata (div_rem),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = (state_r == ST_OUT);
  assign out_coordinate = coord;
  assign out_dim_index  = 3'(d_r);
  assign out_last       = last;

endmodule
